/* hdl/gfsr_tsg_pkg.sv */
package gfsr_tsg_pkg;

  localparam int unsigned LAG_WORDS     = 17;
  localparam int unsigned MIX_SPAN      = 32;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned DIV60_SHIFT   = 37;
  localparam int unsigned LAG_SHL       = 23;
  localparam int unsigned LAG_SHR       = 9;

  localparam logic [WORD_W-1:0] LCG_MUL     = 32'h5D58_8B65;
  localparam logic [WORD_W-1:0] LCG_INC     = 32'h0000_0001;
  localparam logic [WORD_W-1:0] DIV60_RECIP = 32'h8888_8889;
  localparam logic [9:0]        COUNT_DONE  = 10'h208;

  typedef enum logic {
    KIND_SEED = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

endpackage

/* hdl/gfsr_tsg_ram.sv */
module gfsr_tsg_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 521
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/gfsr_tsg_gen.sv */
module gfsr_tsg_gen
  import gfsr_tsg_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 521,
  parameter int unsigned AW         = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] tick,
  output logic              wr_en,
  output logic [AW-1:0]     wr_addr,
  output logic [BYTE_W-1:0] wr_data,
  output logic              done
);

  typedef enum logic [2:0] {
    G_IDLE,
    G_DIV,
    G_LCG,
    G_PRE,
    G_EXP
  } gen_state_t;

  gen_state_t        state_r, state_nxt;
  logic [WORD_W-1:0] tick_r, tick_nxt;
  logic [WORD_W-1:0] s_r, s_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [4:0]        bit_cnt_r, bit_cnt_nxt;
  logic [4:0]        word_cnt_r, word_cnt_nxt;
  logic [AW-1:0]     step_r, step_nxt;
  logic [WORD_W-1:0] win_r [LAG_WORDS];
  logic [WORD_W-1:0] win_nxt [LAG_WORDS];

  logic [2*WORD_W-1:0] div_prod;
  logic [WORD_W-1:0]   lcg_next;
  logic                last_step;

  assign div_prod  = {{WORD_W{1'b0}}, tick_r} * {{WORD_W{1'b0}}, DIV60_RECIP};
  assign lcg_next  = s_r * LCG_MUL + LCG_INC;
  assign last_step = (step_r == AW'(TABLE_SIZE - 1));

  assign wr_en   = (state_r == G_EXP);
  assign wr_addr = step_r;
  assign wr_data = win_r[0][BYTE_W-1:0];
  assign done    = (state_r == G_EXP) && last_step;

  always_comb begin
    state_nxt    = state_r;
    tick_nxt     = tick_r;
    s_nxt        = s_r;
    acc_nxt      = acc_r;
    bit_cnt_nxt  = bit_cnt_r;
    word_cnt_nxt = word_cnt_r;
    step_nxt     = step_r;
    for (int k = 0; k < LAG_WORDS; k++) begin
      win_nxt[k] = win_r[k];
    end
    case (state_r)
      G_IDLE: begin
        if (start) begin
          tick_nxt  = tick;
          state_nxt = G_DIV;
        end
      end
      G_DIV: begin
        s_nxt        = WORD_W'(div_prod >> DIV60_SHIFT);
        bit_cnt_nxt  = '0;
        word_cnt_nxt = '0;
        state_nxt    = G_LCG;
      end
      G_LCG: begin
        s_nxt       = lcg_next;
        acc_nxt     = {lcg_next[WORD_W-1], acc_r[WORD_W-1:1]};
        bit_cnt_nxt = bit_cnt_r + 5'd1;
        if (bit_cnt_r == 5'(WORD_W - 1)) begin
          for (int k = 0; k < LAG_WORDS - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          win_nxt[LAG_WORDS-1] = acc_nxt;
          word_cnt_nxt = word_cnt_r + 5'd1;
          if (word_cnt_r == 5'(LAG_WORDS - 1)) begin
            state_nxt = G_PRE;
          end
        end
      end
      G_PRE: begin
        win_nxt[LAG_WORDS-1] = (win_r[LAG_WORDS-1] << LAG_SHL) ^ (win_r[0] >> LAG_SHR)
                               ^ win_r[LAG_WORDS-2];
        step_nxt  = '0;
        state_nxt = G_EXP;
      end
      G_EXP: begin
        for (int k = 0; k < LAG_WORDS - 1; k++) begin
          win_nxt[k] = win_r[k+1];
        end
        win_nxt[LAG_WORDS-1] = (win_r[0] << LAG_SHL) ^ (win_r[1] >> LAG_SHR)
                               ^ win_r[LAG_WORDS-1];
        step_nxt = step_r + AW'(1);
        if (last_step) begin
          state_nxt = G_IDLE;
        end
      end
      default: begin
        state_nxt = G_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    tick_r     <= tick_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    word_cnt_r <= word_cnt_nxt;
    step_r     <= step_nxt;
    for (int k = 0; k < LAG_WORDS; k++) begin
      win_r[k] <= win_nxt[k];
    end
  end

endmodule

/* hdl/gfsr_table_seed_generator.sv */
// table of pseudo-random bytes seeded from a timer tick
// input channel: in_kind selects a seed request (regenerate the table from
//   in_tick) or a read request (return the byte at in_index)
// result channel: exactly one result per request; out_data is the byte for
//   a read (0 before the first seeding or for an index past the table end)
//   and 0 for a seed; out_ready_res and out_byte_count report whether a
//   table has been generated since reset
// read requests stream at one per cycle unless the receiver stalls; the result
//   appears in the cycle after acceptance, set by the table memory read port
// a seed request occupies the block through one divide-by-60 multiply, 544
//   generator steps, one pre-step, TABLE_SIZE table writes and two mixing
//   sweeps of TABLE_SIZE read-modify-write steps each through the table
//   memory; its result appears at the end, and no request is accepted
//   meanwhile
// reset clears the ready flag; table contents are not cleared
// while the receiver stalls, the result holds and in_stall is raised, so
//   no further request is taken until the pending result leaves
module gfsr_table_seed_generator
  import gfsr_tsg_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 521
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_tick,
  input  logic [9:0]  in_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data,
  output logic        out_ready_res,
  output logic [9:0]  out_byte_count
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);

  typedef enum logic [1:0] {
    T_IDLE,
    T_GEN,
    T_MIX
  } top_state_t;

  top_state_t      state_r, state_nxt;
  logic            table_valid_r, table_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_sel_ram_r, out_sel_ram_nxt;
  logic            out_ready_r, out_ready_nxt;
  logic            iss_r, iss_nxt;
  logic            pass_r, pass_nxt;
  logic [AW-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic            p_vld_r, p_vld_nxt;
  logic            p_last_r, p_last_nxt;
  logic [AW-1:0]   p_addr_r, p_addr_nxt;
  logic [7:0]      hist_r [MIX_SPAN];

  logic            accept;
  logic            gen_start;
  logic            gen_wr_en;
  logic [AW-1:0]   gen_wr_addr;
  logic [7:0]      gen_wr_data;
  logic            gen_done;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;
  logic [7:0]      mix_byte;
  logic            push;
  logic [7:0]      push_data;

  assign in_stall = (state_r != T_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign gen_start = accept && (kind_t'(in_kind) == KIND_SEED);

  assign mix_byte  = ram_rdata ^ hist_r[0];
  assign push      = gen_wr_en || p_vld_r;
  assign push_data = gen_wr_en ? gen_wr_data : mix_byte;

  assign ram_we    = gen_wr_en || p_vld_r;
  assign ram_waddr = gen_wr_en ? gen_wr_addr : p_addr_r;
  assign ram_wdata = push_data;
  assign ram_re    = (state_r == T_MIX) ? iss_r
                                        : (accept && (kind_t'(in_kind) == KIND_READ));
  assign ram_raddr = (state_r == T_MIX) ? rd_cnt_r : in_index[AW-1:0];

  assign out_valid      = out_valid_r;
  assign out_data       = out_sel_ram_r ? ram_rdata : 8'd0;
  assign out_ready_res  = out_ready_r;
  assign out_byte_count = out_ready_r ? COUNT_DONE : 10'd0;

  gfsr_tsg_gen #(
    .TABLE_SIZE (TABLE_SIZE),
    .AW         (AW)
  ) u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (gen_start),
    .tick    (in_tick),
    .wr_en   (gen_wr_en),
    .wr_addr (gen_wr_addr),
    .wr_data (gen_wr_data),
    .done    (gen_done)
  );

  gfsr_tsg_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    table_valid_nxt = table_valid_r;
    out_valid_nxt   = out_valid_r;
    out_sel_ram_nxt = out_sel_ram_r;
    out_ready_nxt   = out_ready_r;
    iss_nxt         = iss_r;
    pass_nxt        = pass_r;
    rd_cnt_nxt      = rd_cnt_r;
    p_vld_nxt       = 1'b0;
    p_last_nxt      = p_last_r;
    p_addr_nxt      = p_addr_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      T_IDLE: begin
        if (accept) begin
          if (kind_t'(in_kind) == KIND_READ) begin
            out_valid_nxt   = 1'b1;
            out_sel_ram_nxt = table_valid_r && (in_index < 10'(TABLE_SIZE));
            out_ready_nxt   = table_valid_r;
          end else begin
            state_nxt = T_GEN;
          end
        end
      end
      T_GEN: begin
        if (gen_done) begin
          state_nxt  = T_MIX;
          iss_nxt    = 1'b1;
          pass_nxt   = 1'b0;
          rd_cnt_nxt = '0;
        end
      end
      T_MIX: begin
        if (iss_r) begin
          p_vld_nxt  = 1'b1;
          p_addr_nxt = rd_cnt_r;
          p_last_nxt = pass_r && (rd_cnt_r == AW'(TABLE_SIZE - 1));
          if (rd_cnt_r == AW'(TABLE_SIZE - 1)) begin
            rd_cnt_nxt = '0;
            pass_nxt   = 1'b1;
            if (pass_r) begin
              iss_nxt = 1'b0;
            end
          end else begin
            rd_cnt_nxt = rd_cnt_r + AW'(1);
          end
        end
        if (p_vld_r && p_last_r) begin
          state_nxt       = T_IDLE;
          table_valid_nxt = 1'b1;
          out_valid_nxt   = 1'b1;
          out_sel_ram_nxt = 1'b0;
          out_ready_nxt   = 1'b1;
        end
      end
      default: begin
        state_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= T_IDLE;
      table_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      iss_r         <= 1'b0;
      p_vld_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      table_valid_r <= table_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      iss_r         <= iss_nxt;
      p_vld_r       <= p_vld_nxt;
    end
    out_sel_ram_r <= out_sel_ram_nxt;
    out_ready_r   <= out_ready_nxt;
    pass_r        <= pass_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    p_last_r      <= p_last_nxt;
    p_addr_r      <= p_addr_nxt;
    if (push) begin
      for (int k = 0; k < MIX_SPAN - 1; k++) begin
        hist_r[k] <= hist_r[k+1];
      end
      hist_r[MIX_SPAN-1] <= push_data;
    end
  end

endmodule

/* tb/gfsr_table_seed_generator_tb.sv */
module gfsr_table_seed_generator_tb;
  import gfsr_tsg_pkg::*;

  localparam int unsigned TABLE_SIZE   = 521;
  localparam int unsigned MIX_TAIL     = TABLE_SIZE - MIX_SPAN;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CYCLE_LIMIT  = 1_500_000;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct {
    logic [7:0] data;
    logic       ready;
    logic [9:0] count;
  } table_result_t;

  class gfsr_table_tracker;
    logic [7:0]    model_bytes [TABLE_SIZE];
    logic [31:0]   lcg_state;
    logic          table_ready;
    table_result_t pending_results [$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   seeds;
    int unsigned   reads;
    int unsigned   past_end_reads;

    function new();
      lcg_state   = '0;
      table_ready = 1'b0;
      mismatches  = 0;
      checked     = 0;
      seeds       = 0;
      reads       = 0;
      past_end_reads = 0;
    endfunction

    function void regenerate_table(logic [31:0] tick);
      logic [63:0] prod;
      logic [31:0] s;
      logic [31:0] acc;
      logic [31:0] w [TABLE_SIZE];
      int          i;
      int          b;
      int          pass;
      prod = 64'(tick) * 64'(DIV60_RECIP);
      s    = 32'(prod >> DIV60_SHIFT);
      for (i = 0; i < LAG_WORDS; i++) begin
        acc = '0;
        for (b = 0; b < WORD_W; b++) begin
          s   = s * LCG_MUL + LCG_INC;
          acc = (acc >> 1) | (s & 32'h8000_0000);
        end
        w[i] = acc;
      end
      lcg_state = s;
      // pre-step on the last lag word before the expansion
      w[LAG_WORDS-1] = (w[LAG_WORDS-1] << LAG_SHL) ^ (w[0] >> LAG_SHR) ^ w[LAG_WORDS-2];
      for (i = LAG_WORDS; i < TABLE_SIZE; i++)
        w[i] = (w[i-LAG_WORDS] << LAG_SHL) ^ (w[i-LAG_WORDS+1] >> LAG_SHR) ^ w[i-1];
      for (i = 0; i < TABLE_SIZE; i++)
        model_bytes[i] = w[i][BYTE_W-1:0];
      for (pass = 0; pass < 2; pass++) begin
        for (i = 0; i < MIX_SPAN; i++)
          model_bytes[i] = model_bytes[i] ^ model_bytes[MIX_TAIL + i];
        for (i = MIX_SPAN; i < TABLE_SIZE; i++)
          model_bytes[i] = model_bytes[i] ^ model_bytes[i - MIX_SPAN];
      end
      table_ready = 1'b1;
    endfunction

    function void note_request(kind_t kind, logic [31:0] tick, logic [9:0] index);
      table_result_t res;
      res.data = '0;
      if (kind == KIND_SEED) begin
        seeds++;
        regenerate_table(tick);
      end else begin
        reads++;
        if (index >= TABLE_SIZE)
          past_end_reads++;
        else if (table_ready)
          res.data = model_bytes[index];
      end
      res.ready = table_ready;
      res.count = table_ready ? COUNT_DONE : 10'd0;
      pending_results.push_back(res);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task check_result(logic [7:0] data, logic ready, logic [9:0] count);
      table_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", 32'(data), 32'h0);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (data !== want.data)
        report_mismatch("out_data", 32'(data), 32'(want.data));
      if (ready !== want.ready)
        report_mismatch("out_ready_res", 32'(ready), 32'(want.ready));
      if (count !== want.count)
        report_mismatch("out_byte_count", 32'(count), 32'(want.count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_kind = KIND_READ;
  logic [31:0] in_tick = '0;
  logic [9:0]  in_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data;
  logic        out_ready_res;
  logic [9:0]  out_byte_count;

  gfsr_table_tracker tracker = new();

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  gfsr_table_seed_generator #(
    .TABLE_SIZE(TABLE_SIZE)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_tick(in_tick),
    .in_index(in_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .out_ready_res(out_ready_res),
    .out_byte_count(out_byte_count)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               tracker.pending());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: long hold-offs counted here, otherwise random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_taken != hold_requests) begin
      hold_taken = hold_requests;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_data, out_ready_res, out_byte_count);
  end

  task automatic send_request(kind_t kind, logic [31:0] tick, logic [9:0] index);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_tick  <= tick;
    in_index <= index;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    tracker.note_request(kind, tick, index);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0)
      @(negedge clk);
  endtask

  task automatic send_random_request();
    int unsigned roll;
    logic [31:0] tick;
    logic [9:0]  index;
    roll  = $urandom_range(99);
    tick  = $urandom;
    index = 10'($urandom_range(TABLE_SIZE - 1));
    if (roll < 3) begin
      case ($urandom_range(7))
        0: tick = '0;
        1: tick = '1;
        2: tick = 32'd59;
        3: tick = 32'd60;
        default: ;
      endcase
      send_request(KIND_SEED, tick, 10'($urandom));
    end else if (roll < 12) begin
      send_request(KIND_READ, tick, 10'($urandom_range(1023, TABLE_SIZE)));
    end else if (roll < 17) begin
      send_request(KIND_READ, tick, 10'($urandom));
    end else begin
      send_request(KIND_READ, tick, index);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned burst;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reads before any seeding, then seeds with reads at the table edges
    send_request(KIND_READ, 32'hFFFF_FFFF, 10'd0);
    send_request(KIND_READ, 32'h0, 10'd520);
    send_request(KIND_READ, 32'h1234_5678, 10'h3FF);
    send_request(KIND_SEED, 32'h0, 10'h3FF);
    send_request(KIND_READ, 32'h0, 10'd0);
    send_request(KIND_READ, 32'h0, 10'd520);
    send_request(KIND_READ, 32'h0, 10'd521);
    send_request(KIND_READ, 32'hFFFF_FFFF, 10'h3FF);
    send_request(KIND_SEED, 32'hFFFF_FFFF, 10'd0);
    send_request(KIND_READ, 32'hA5A5_A5A5, 10'd0);
    send_request(KIND_READ, 32'h5A5A_5A5A, 10'd31);
    send_request(KIND_READ, 32'h0, 10'd32);
    send_request(KIND_READ, 32'h0, 10'd488);
    send_request(KIND_READ, 32'h0, 10'd489);
    send_request(KIND_READ, 32'h0, 10'd520);
    send_request(KIND_SEED, 32'd59, 10'd520);
    send_request(KIND_READ, 32'h0, 10'd1);
    send_request(KIND_SEED, 32'd60, 10'h2AA);
    send_request(KIND_READ, 32'h0, 10'd1);
    send_request(KIND_READ, 32'h0, 10'd519);
    send_request(KIND_READ, 32'h0, 10'h200);
    wait_drained();
    @(negedge clk);

    for (phase = 0; phase < PHASES; phase++) begin
      sender_idle_pct    = (phase % 4 == 1) ? 86 : (phase % 4 == 3) ? 13 : 0;
      receiver_stall_pct = (phase % 4 == 2) ? 86 : (phase % 4 == 3) ? 13 : 0;
      if (phase == 0 || phase == 4)
        hold_requests = hold_requests + 1;
      n = 0;
      while (n < RANDOM_ITEMS / PHASES) begin
        // burst of back-to-back random requests (mostly reads) every so often
        if ($urandom_range(9) == 0) begin
          sender_idle_pct = 0;
          burst = $urandom_range(40, 5);
          repeat (burst) send_random_request();
          n = n + burst;
          sender_idle_pct = (phase % 4 == 1) ? 86 : (phase % 4 == 3) ? 13 : 0;
        end
        send_random_request();
        n = n + 1;
      end
      wait_drained();
      @(negedge clk);
    end

    wait_drained();
    receiver_stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("covered %0d seeds and %0d reads (%0d past the table end), %0d results checked",
             tracker.seeds, tracker.reads, tracker.past_end_reads, tracker.checked);
    $display("idle and stall mixes in %0d phases, two long receiver hold-offs", PHASES);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* gfsr_table_seed_generator.f */
hdl/gfsr_tsg_pkg.sv
hdl/gfsr_tsg_ram.sv
hdl/gfsr_tsg_gen.sv
hdl/gfsr_table_seed_generator.sv
tb/gfsr_table_seed_generator_tb.sv
